/* hdl/odo_pkg.sv */
`timescale 1ns / 1ps
// Package for the differential drive odometry block.
// Holds the payload and CORDIC lane types, register codes and the arctangent table.
// Depends on nothing; every other file imports it.
package odo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 30;
    localparam int CHAIN_LEN = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int SHIFT_W = $clog2(ATAN_ENTRIES);
    localparam int ROT_W = 34;
    localparam int CFG_IDX_W = 8;

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN_Q30 = ROT_W'(652032874);
    localparam logic [31:0] MPU_RESET = 32'd65536;
    localparam logic [31:0] GAIN_RESET = 32'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_METERS_PER_UNIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN = CFG_IDX_W'(1);

    localparam logic [31:0] ATAN_BAM [0:ATAN_ENTRIES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    typedef struct packed {
        logic signed [31:0] left_wheel_pos;
        logic signed [31:0] right_wheel_pos;
    } t_odo_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0] heading;
    } t_odo_out;

    typedef struct packed {
        logic valid;
        logic flip;
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
    } t_rot_lane;

endpackage

/* hdl/odo_cordic_cell.sv */
`timescale 1ns / 1ps
// One CORDIC rotation cell: a single micro-rotation with a fixed shift and angle.
// Depends on odo_pkg for the lane type.
module odo_cordic_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [odo_pkg::SHIFT_W-1:0] i_shift,
    input  logic [31:0]                i_atan,
    input  odo_pkg::t_rot_lane         i_prev,
    output odo_pkg::t_rot_lane         o_next
);
    import odo_pkg::*;

    t_rot_lane r_lane;
    t_rot_lane n_lane;
    logic signed [ROT_W-1:0] w_x;
    logic signed [ROT_W-1:0] w_y;
    logic signed [ROT_W-1:0] w_xs;
    logic signed [ROT_W-1:0] w_ys;
    logic signed [ROT_W-1:0] w_atan;

    always_comb begin
        w_x = i_prev.x;
        w_y = i_prev.y;
        w_xs = w_x >>> i_shift;
        w_ys = w_y >>> i_shift;
        w_atan = $signed({{(ROT_W-32){1'b0}}, i_atan});
        n_lane = i_prev;
        if (!i_prev.z[ROT_W-1]) begin
            n_lane.x = w_x - w_ys;
            n_lane.y = w_y + w_xs;
            n_lane.z = i_prev.z - w_atan;
        end else begin
            n_lane.x = w_x + w_ys;
            n_lane.y = w_y - w_xs;
            n_lane.z = i_prev.z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= '0;
        end else begin
            r_lane <= n_lane;
        end
    end

    assign o_next = r_lane;

endmodule

/* hdl/odo_cordic.sv */
`timescale 1ns / 1ps
// Rotation-mode CORDIC built as a row of cells, with the quadrant fold at the
// entry and the sign restore at the exit. Depends on odo_pkg and odo_cordic_cell.
module odo_cordic (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [31:0]               i_angle,
    output logic                      o_done,
    output logic signed [odo_pkg::ROT_W-1:0] o_cos,
    output logic signed [odo_pkg::ROT_W-1:0] o_sin
);
    import odo_pkg::*;

    t_rot_lane w_lane [0:CHAIN_LEN];
    logic w_flip;
    logic [31:0] w_angle;
    logic r_done;
    logic signed [ROT_W-1:0] r_cos;
    logic signed [ROT_W-1:0] r_sin;

    always_comb begin
        w_flip = (i_angle[31:30] == 2'b01) || (i_angle[31:30] == 2'b10);
        w_angle = {i_angle[31] ^ w_flip, i_angle[30:0]};
        w_lane[0].valid = i_start;
        w_lane[0].flip = w_flip;
        w_lane[0].x = CORDIC_GAIN_Q30;
        w_lane[0].y = '0;
        w_lane[0].z = $signed({{(ROT_W-32){w_angle[31]}}, w_angle});
    end

    for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
        odo_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (SHIFT_W'(k)),
            .i_atan  (ATAN_BAM[k]),
            .i_prev  (w_lane[k]),
            .o_next  (w_lane[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_lane[CHAIN_LEN].valid;
        end
        r_cos <= w_lane[CHAIN_LEN].flip ? -w_lane[CHAIN_LEN].x : w_lane[CHAIN_LEN].x;
        r_sin <= w_lane[CHAIN_LEN].flip ? -w_lane[CHAIN_LEN].y : w_lane[CHAIN_LEN].y;
    end

    assign o_done = r_done;
    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

/* hdl/differential_drive_odometry_top.sv */
`timescale 1ns / 1ps
// Top level of the differential drive odometry block: handshakes, configuration,
// wheel travel, heading update and pose integration. Depends on odo_pkg and odo_cordic.
//
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall  i_in_data (t_odo_in)
// out       output     o_out_valid / i_out_stall o_out_data (t_odo_out)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One transaction is worked on at a time; it passes the travel, head, start, rotate
// and commit states, rotate waiting on the CORDIC cells and commit on a free output.
// The next input can be taken once the result is registered and the block is idle.
// Reset is synchronous, clears pose and last encoder readings and reloads the registers.
// A stalled output holds the finished pose while the block may take the next input.
module differential_drive_odometry_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  odo_pkg::t_odo_in                  i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output odo_pkg::t_odo_out                 o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [odo_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import odo_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_TRAVEL = 6'b000010,
        S_HEAD   = 6'b000100,
        S_START  = 6'b001000,
        S_ROTATE = 6'b010000,
        S_COMMIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [31:0] r_mpu;
    logic [31:0] r_gain;
    logic [31:0] r_last_left;
    logic [31:0] r_last_right;
    logic [31:0] r_pose_x;
    logic [31:0] r_pose_y;
    logic [31:0] r_pose_heading;
    logic signed [31:0] r_dl;
    logic signed [31:0] r_dr;
    logic signed [31:0] r_tl;
    logic signed [31:0] r_tr;
    logic [31:0] r_dtheta;
    logic [31:0] r_half;
    logic signed [31:0] r_mean;
    logic [31:0] r_dx;
    logic [31:0] r_dy;
    t_odo_out r_out;
    logic r_out_valid;

    logic w_in_accept;
    logic w_out_free;
    logic signed [64:0] n_pl;
    logic signed [64:0] n_pr;
    logic signed [32:0] w_diff;
    logic signed [32:0] w_sum;
    logic signed [65:0] n_ph;
    logic [31:0] w_mid;
    logic w_done;
    logic signed [ROT_W-1:0] w_cos;
    logic signed [ROT_W-1:0] w_sin;
    logic signed [65:0] n_px;
    logic signed [65:0] n_py;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    always_comb begin
        n_pl = r_dl * $signed({1'b0, r_mpu});
        n_pr = r_dr * $signed({1'b0, r_mpu});
        w_diff = {r_tr[31], r_tr} - {r_tl[31], r_tl};
        w_sum = {r_tl[31], r_tl} + {r_tr[31], r_tr};
        n_ph = w_diff * $signed({1'b0, r_gain});
        w_mid = r_pose_heading + r_half;
        n_px = r_mean * w_cos;
        n_py = r_mean * w_sin;
    end

    odo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_angle (w_mid),
        .o_done  (w_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_TRAVEL;
                end
            end
            S_TRAVEL: n_state = S_HEAD;
            S_HEAD: n_state = S_START;
            S_START: n_state = S_ROTATE;
            S_ROTATE: begin
                if (w_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mpu <= MPU_RESET;
            r_gain <= GAIN_RESET;
            r_last_left <= '0;
            r_last_right <= '0;
            r_pose_x <= '0;
            r_pose_y <= '0;
            r_pose_heading <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_METERS_PER_UNIT: r_mpu <= i_cfg_data;
                    REG_HEADING_GAIN: r_gain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_in_accept) begin
                r_last_left <= i_in_data.left_wheel_pos;
                r_last_right <= i_in_data.right_wheel_pos;
            end
            if (r_state == S_COMMIT && w_out_free) begin
                r_pose_x <= r_pose_x + r_dx;
                r_pose_y <= r_pose_y + r_dy;
                r_pose_heading <= r_pose_heading + r_dtheta;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_dl <= i_in_data.left_wheel_pos - r_last_left;
            r_dr <= i_in_data.right_wheel_pos - r_last_right;
        end
        if (r_state == S_TRAVEL) begin
            r_tl <= n_pl[47:16];
            r_tr <= n_pr[47:16];
        end
        if (r_state == S_HEAD) begin
            r_dtheta <= n_ph[47:16];
            r_half <= n_ph[48:17];
            r_mean <= w_sum[32:1];
        end
        if (r_state == S_ROTATE && w_done) begin
            r_dx <= n_px[61:30];
            r_dy <= n_py[61:30];
        end
        if (r_state == S_COMMIT && w_out_free) begin
            r_out.pos_x <= r_pose_x + r_dx;
            r_out.pos_y <= r_pose_y + r_dy;
            r_out.heading <= r_pose_heading + r_dtheta;
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_in_stall)
        else $error("input accepted while a transaction is still in progress");

    a_done_in_rotate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_ROTATE))
        else $error("CORDIC result arrived outside the rotate state");

    a_commit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_out_valid && i_out_stall) |=>
            (r_state == S_COMMIT && r_out_valid))
        else $error("pose committed over a pending result");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for differential_drive_odometry_top: drives encoder readings and
// register writes, predicts every pose in-line and compares it field by field.
// Depends on odo_pkg and the top level of the odometry block.
module tb;
    import odo_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int RESET_CYCLES = 5;
    localparam int IDLE_PCT = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_READINGS = 150;
    localparam logic [31:0] ONE_METER = 32'h0001_0000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(7);

    localparam int ROT_STEPS = (CORDIC_STEPS > 30) ? 30 : CORDIC_STEPS;
    localparam longint ROT_GAIN = 652032874;
    localparam longint ARCTAN_STEP [0:29] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_odo_in in_data = '0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic o_in_stall;
    logic o_out_valid;
    t_odo_out o_out_data;
    logic o_cfg_ready;

    bit idle_en = 1'b1;
    bit hold_req = 1'b0;
    int err_count = 0;

    logic [31:0] unit_scale = MPU_RESET;
    logic [31:0] turn_gain = GAIN_RESET;
    logic [31:0] last_left = '0;
    logic [31:0] last_right = '0;
    logic [31:0] pose_x = '0;
    logic [31:0] pose_y = '0;
    logic [31:0] pose_heading = '0;

    t_odo_out pose_queue[$];

    differential_drive_odometry_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic longint wheel_travel(logic [31:0] now, logic [31:0] prev);
        logic [31:0] diff;
        longint scaled;
        logic [63:0] bits;
        diff = now - prev;
        scaled = (longint'($signed(diff)) * longint'({32'b0, unit_scale})) >>> 16;
        bits = scaled;
        return longint'($signed(bits[31:0]));
    endfunction

    function automatic void rotate_unit(input logic [31:0] angle, output longint c,
                                        output longint s);
        bit flip;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        flip = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
        if (flip) begin
            angle = angle - 32'h8000_0000;
        end
        x = ROT_GAIN;
        y = 0;
        z = longint'($signed(angle));
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_STEP[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_STEP[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic t_odo_out advance_pose(t_odo_in item);
        longint tl;
        longint tr;
        longint mean;
        longint c;
        longint s;
        longint dx;
        longint dy;
        logic [63:0] span;
        logic [63:0] turn;
        logic [31:0] mid;
        t_odo_out pose;
        tl = wheel_travel(item.left_wheel_pos, last_left);
        tr = wheel_travel(item.right_wheel_pos, last_right);
        span = tr - tl;
        turn = span * {32'b0, turn_gain};
        mid = pose_heading + turn[48:17];
        mean = (tl + tr) >>> 1;
        rotate_unit(mid, c, s);
        dx = (mean * c) >>> 30;
        dy = (mean * s) >>> 30;
        pose_x = pose_x + 32'(dx);
        pose_y = pose_y + 32'(dy);
        pose_heading = pose_heading + turn[47:16];
        last_left = item.left_wheel_pos;
        last_right = item.right_wheel_pos;
        pose.pos_x = pose_x;
        pose.pos_y = pose_y;
        pose.heading = pose_heading;
        return pose;
    endfunction

    function automatic void check_pose(t_odo_out got);
        t_odo_out want;
        if (pose_queue.size() == 0) begin
            $error("unexpected pose transaction: %h", got);
            err_count++;
            return;
        end
        want = pose_queue.pop_front();
        if (got.pos_x !== want.pos_x) begin
            $error("pos_x mismatch: expected %h, actual %h", want.pos_x, got.pos_x);
            err_count++;
        end
        if (got.pos_y !== want.pos_y) begin
            $error("pos_y mismatch: expected %h, actual %h", want.pos_y, got.pos_y);
            err_count++;
        end
        if (got.heading !== want.heading) begin
            $error("heading mismatch: expected %h, actual %h", want.heading, got.heading);
            err_count++;
        end
    endfunction

    function automatic t_odo_in reading(logic [31:0] left, logic [31:0] right);
        t_odo_in r;
        r.left_wheel_pos = left;
        r.right_wheel_pos = right;
        return r;
    endfunction

    function automatic t_odo_in next_reading();
        int span;
        int dl;
        int dr;
        if ($urandom_range(99) < 75) begin
            span = 1 << $urandom_range(4, 24);
            dl = int'($urandom_range(0, span)) - span / 2;
            dr = dl + int'($urandom_range(0, span / 4)) - span / 8;
            return reading(last_left + 32'(dl), last_right + 32'(dr));
        end
        return reading($urandom, $urandom);
    endfunction

    task automatic send_reading(input t_odo_in item);
        while (idle_en && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (o_in_stall);
        pose_queue.push_back(advance_pose(item));
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (pose_queue.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!o_cfg_ready);
        if (idx == REG_METERS_PER_UNIT) begin
            unit_scale = value;
        end else if (idx == REG_HEADING_GAIN) begin
            turn_gain = value;
        end
    endtask

    task automatic set_geometry(input logic [31:0] scale, input logic [31:0] gain);
        wait_results_done();
        write_register(REG_METERS_PER_UNIT, scale);
        write_register(REG_HEADING_GAIN, gain);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_motion();
        send_reading(reading(32'h0, 32'h0));
        send_reading(reading(10 * ONE_METER, 10 * ONE_METER));
        send_reading(reading(5 * ONE_METER, 15 * ONE_METER));
        send_reading(reading(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_reading(reading(32'h8000_0000, 32'h8000_0000));
        send_reading(reading(32'h7FFF_FFFF, 32'h8000_0000));
        send_reading(reading(32'h0, 32'h0));
        send_reading(reading(32'hFFFF_FFFF, 32'h0000_0001));
    endtask

    task automatic test_extreme_registers();
        wait_results_done();
        write_register(REG_SPARE, $urandom);
        set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_reading(reading(32'h0001_0000, 32'hFFFF_0000));
        send_reading(reading(32'h8000_0000, 32'h7FFF_FFFF));
        send_reading(reading(32'h1234_5678, 32'hEDCB_A987));
        send_reading(reading(32'h0, 32'h0));
        send_reading(reading(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        set_geometry(32'h0, 32'h0);
        send_reading(reading(32'h5555_5555, 32'hAAAA_AAAA));
        send_reading(reading(32'hAAAA_AAAA, 32'h5555_5555));
    endtask

    task automatic test_quarter_turns();
        set_geometry(ONE_METER, 32'h4000_0000);
        for (int k = 1; k <= 5; k++) begin
            send_reading(reading(32'h5555_5555 + k * ONE_METER,
                                 32'hAAAA_AAAA + 2 * k * ONE_METER));
        end
    endtask

    task automatic test_random_sweep();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_geometry(MPU_RESET, $urandom_range(0, 32'h4000_0000));
                1: set_geometry($urandom_range(1, 32'h0004_0000), $urandom);
                2: set_geometry(32'hFFFF_FFFF, $urandom);
                3: set_geometry($urandom, 32'hFFFF_FFFF);
                default: set_geometry($urandom, $urandom);
            endcase
            idle_en = (phase != 0);
            repeat (PHASE_READINGS) send_reading(next_reading());
        end
        idle_en = 1'b1;
    endtask

    task automatic test_output_backpressure();
        wait_results_done();
        hold_req <= ~hold_req;
        repeat (60) send_reading(next_reading());
        wait_results_done();
    endtask

    task automatic test_sender_pause();
        repeat (20) send_reading(next_reading());
        wait_results_done();
        repeat (20) send_reading(next_reading());
    endtask

    initial begin : result_monitor
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge clk);
            if (o_out_valid && !out_stall) begin
                check_pose(o_out_data);
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_motion();
        test_extreme_registers();
        test_quarter_turns();
        test_random_sweep();
        test_output_backpressure();
        test_sender_pause();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pose_queue.size() != 0) begin
            $error("%0d expected poses never arrived", pose_queue.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/odo_pkg.sv
hdl/odo_cordic_cell.sv
hdl/odo_cordic.sv
hdl/differential_drive_odometry_top.sv
tb/sv/tb.sv
